// ----- hw/rtl/rgwep_pkg.sv -----
// Package for the weighted edge picker that builds random regular graphs.
// Holds the shared constants, result status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package rgwep_pkg;

    localparam int unsigned DEF_MAX_VERTICES = 64;
    localparam int unsigned CFG_W            = 7;
    localparam int unsigned FRAC_W           = 32;
    localparam int unsigned STATUS_W         = 3;
    localparam int unsigned VTX_OUT_W        = 6;
    localparam int unsigned EDGE_OUT_W       = 11;
    localparam int unsigned DEG_W            = 7;

    localparam logic [CFG_W-1:0] RST_NUM_VERTICES  = 7'd64;
    localparam logic [CFG_W-1:0] RST_TARGET_DEGREE = 7'd2;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    // Register index, taken from paddr bit 2.
    localparam logic REG_NUM_VERTICES  = 1'b0;
    localparam logic REG_TARGET_DEGREE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_EDGE       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STARTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COMPLETE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CONFIG = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_SCAN,
        S_DEG_I,
        S_DEG_J,
        S_DEG_W,
        S_REFRESH,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/rgwep_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module rgwep_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/regular_graph_weighted_edge_picker_core.sv -----
// Top level of the random regular graph edge picker: sequencer, datapath and stores.
// Depends on rgwep_pkg and rgwep_ram.
//
// Usage: configure num_vertices (address 0) and target_degree (address 4) over
// the APB-style port while the block is idle, then send a start item (op 0),
// followed by draw items (op 1) each carrying a 32-bit random fraction.
// Every input transfer produces exactly one result transfer.
// The block takes one item at a time: o_in_stall is high from the cycle after
// an input transfer until the result has been loaded into the output register.
// A start sweeps the pair store one slot per cycle over max(n*(n-1)/2, n)
// slots, then loads the result. A draw first forms u*total, then scans the
// pair store at one slot per cycle, updates the two endpoint degrees and
// refreshes the rows and columns of both endpoints through the weight and
// degree RAM ports. Other items go straight to the result.
// Reset is synchronous; it restores the registers to 64 vertices and degree 2
// and marks the configuration invalid, so a start is needed before drawing.
// A stalled result holds in the output register; the next result waits for it.
`default_nettype none

module regular_graph_weighted_edge_picker_core
    import rgwep_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_op,
    input  wire logic [FRAC_W-1:0]     i_random_fraction,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [VTX_OUT_W-1:0]       o_vertex_high,
    output logic [VTX_OUT_W-1:0]       o_vertex_low,
    output logic [EDGE_OUT_W-1:0]      o_edge_count,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int unsigned VW    = $clog2(MAX_VERTICES);
    localparam int unsigned VCW   = VW + 1;
    localparam int unsigned NXW   = (VCW > CFG_W) ? VCW : CFG_W;
    localparam int unsigned DMAX  = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;
    localparam int unsigned PAIRS = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
    localparam int unsigned RAM_D = (PAIRS < 2) ? 2 : PAIRS;
    localparam int unsigned AW    = $clog2(RAM_D);
    localparam int unsigned WW    = $clog2(DMAX * DMAX + 1);
    localparam int unsigned TW    = $clog2((DMAX * (DMAX - 1) / 2) * DMAX * DMAX + 1);
    localparam int unsigned EW    = $clog2(DMAX * DMAX / 2 + 1);
    localparam int unsigned CW    = $clog2(RAM_D + MAX_VERTICES + 1);
    localparam int unsigned XW    = (CW > 13) ? CW : 13;
    localparam int unsigned PW    = FRAC_W + TW;

    // Slot of pair (hi, lo) with hi > lo in the lower-triangular store.
    function automatic logic [AW-1:0] slot_of(input logic [VW-1:0] hi,
                                              input logic [VW-1:0] lo);
        logic [2*VW-1:0] p;
        p = (2*VW)'(hi) * (2*VW)'(hi - VW'(1));
        return AW'((p >> 1) + (2*VW)'(lo));
    endfunction

    // Pair weight from the degree target and two current degrees.
    function automatic logic [WW-1:0] fresh(input logic [CFG_W-1:0] d,
                                            input logic [DEG_W-1:0] dv,
                                            input logic [DEG_W-1:0] dk);
        logic [13:0] p;
        if (dv >= d || dk >= d) begin
            p = '0;
        end else begin
            p = 14'(d - dv) * 14'(d - dk);
        end
        return WW'(p);
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_nv, n_nv, r_td, n_td;
    logic                r_cfg_ok, n_cfg_ok;
    logic [TW-1:0]       r_total, n_total;
    logic [EW-1:0]       r_edges, n_edges;
    logic [FRAC_W-1:0]   r_u, n_u;
    logic [CW-1:0]       r_c, n_c;
    logic [TW-1:0]       r_lhs, n_lhs;
    logic [VW-1:0]       r_si, n_si, r_sj, n_sj;
    logic [AW-1:0]       r_slot, n_slot;
    logic                r_idone, n_idone;
    logic                r_pv, n_pv;
    logic [VW-1:0]       r_pi, n_pi, r_pj, n_pj;
    logic [AW-1:0]       r_pslot, n_pslot;
    logic [TW-1:0]       r_cum, n_cum;
    logic [VW-1:0]       r_fi, n_fi, r_fj, n_fj;
    logic [DEG_W-1:0]    r_di, n_di, r_dj, n_dj;
    logic                r_sel, n_sel;
    logic [VW-1:0]       r_k, n_k;
    logic                r_rdone, n_rdone;
    logic                r_qv, n_qv;
    logic [AW-1:0]       r_qslot, n_qslot;
    logic [DEG_W-1:0]    r_qdv, n_qdv;
    logic [STATUS_W-1:0] r_res, n_res;
    logic [VW-1:0]       r_res_hi, n_res_hi, r_res_lo, n_res_lo;
    logic                r_ov, n_ov;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [VTX_OUT_W-1:0] r_o_hi, n_o_hi, r_o_lo, n_o_lo;
    logic [EDGE_OUT_W-1:0] r_o_edges, n_o_edges;

    // Store ports.
    logic             w_we;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [WW-1:0]    w_wdata, w_rd;
    logic             d_we;
    logic [VW-1:0]    d_waddr, d_raddr;
    logic [DEG_W-1:0] d_wdata, d_rd;

    logic             in_acc, cfg_we, out_free, bad_cfg;
    logic [NXW-1:0]   nx;
    logic [12:0]      pn, lim;
    logic [13:0]      half_nd;
    logic [WW-1:0]    dd;
    logic [PW-1:0]    prod;
    logic [TW-1:0]    cum_new;
    logic             scan_hit, scan_miss, sweep_last, ref_end;
    logic [VW-1:0]    ref_v, ref_hi, ref_lo;

    rgwep_ram #(.WIDTH(WW), .DEPTH(RAM_D)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    rgwep_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_degree_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rd)
    );

    // Handshake and configuration decode.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_we     = psel && penable && pwrite;
    assign out_free   = !r_ov || !i_out_stall;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_TARGET_DEGREE) ? 32'(r_td) : 32'(r_nv);

    // Configuration derived values.
    assign nx      = NXW'(r_nv);
    assign pn      = 13'((14'(r_nv) * 14'(r_nv - CFG_W'(1))) >> 1);
    assign lim     = (pn > 13'(r_nv)) ? pn : 13'(r_nv);
    assign half_nd = (14'(r_nv) * 14'(r_td)) >> 1;
    assign dd      = WW'(14'(r_td) * 14'(r_td));
    assign bad_cfg = (r_nv == '0) || (nx > NXW'(MAX_VERTICES)) || (r_td > r_nv)
                     || (r_nv[0] && r_td[0]);

    // Shared arithmetic: product, running sum and loop end tests.
    assign prod       = PW'(r_u) * PW'(r_total);
    assign cum_new    = r_cum + TW'(w_rd);
    assign scan_hit   = r_pv && (w_rd != '0) && (r_lhs < cum_new);
    assign scan_miss  = !r_pv && r_idone;
    assign sweep_last = (XW'(r_c) == (XW'(lim) - XW'(1)));
    assign ref_end    = r_rdone && !r_qv;
    assign ref_v      = r_sel ? r_fj : r_fi;
    assign ref_hi     = (r_k > ref_v) ? r_k : ref_v;
    assign ref_lo     = (r_k > ref_v) ? ref_v : r_k;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_op == OP_START) begin
                        n_state = bad_cfg ? S_RESULT : S_START;
                    end else if (!r_cfg_ok || r_total == '0) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_START:   if (sweep_last) n_state = S_RESULT;
            S_MUL:     n_state = S_SCAN;
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_DEG_I;
                end else if (scan_miss) begin
                    n_state = S_RESULT;
                end
            end
            S_DEG_I:   n_state = S_DEG_J;
            S_DEG_J:   n_state = S_DEG_W;
            S_DEG_W:   n_state = S_REFRESH;
            S_REFRESH: if (ref_end) n_state = S_RESULT;
            S_RESULT:  if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, store controls and output register loading.
    always_comb begin
        n_nv = r_nv;         n_td = r_td;         n_cfg_ok = r_cfg_ok;
        n_total = r_total;   n_edges = r_edges;   n_u = r_u;
        n_c = r_c;           n_lhs = r_lhs;       n_si = r_si;
        n_sj = r_sj;         n_slot = r_slot;     n_idone = r_idone;
        n_pv = r_pv;         n_pi = r_pi;         n_pj = r_pj;
        n_pslot = r_pslot;   n_cum = r_cum;       n_fi = r_fi;
        n_fj = r_fj;         n_di = r_di;         n_dj = r_dj;
        n_sel = r_sel;       n_k = r_k;           n_rdone = r_rdone;
        n_qv = r_qv;         n_qslot = r_qslot;   n_qdv = r_qdv;
        n_res = r_res;       n_res_hi = r_res_hi; n_res_lo = r_res_lo;
        n_ov = r_ov;         n_o_status = r_o_status;
        n_o_hi = r_o_hi;     n_o_lo = r_o_lo;     n_o_edges = r_o_edges;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
        d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;

        // A taken result frees the output register.
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_u      = i_random_fraction;
                    n_res_hi = '0;
                    n_res_lo = '0;
                    if (i_op == OP_START) begin
                        n_total = '0;
                        n_edges = '0;
                        n_c     = '0;
                        if (bad_cfg) begin
                            n_cfg_ok = 1'b0;
                            n_res    = ST_BAD_CONFIG;
                        end
                    end else if (!r_cfg_ok) begin
                        n_res = ST_BAD_CONFIG;
                    end else if (r_total == '0) begin
                        n_res = (14'(r_edges) == half_nd) ? ST_COMPLETE : ST_INCOMPLETE;
                    end
                end
            end
            S_START: begin
                // Fill pairs with d*d and clear degrees, one slot a cycle.
                w_waddr = AW'(r_c);
                w_wdata = dd;
                w_we    = XW'(r_c) < XW'(pn);
                d_waddr = VW'(r_c);
                d_we    = XW'(r_c) < XW'(nx);
                if (w_we) begin
                    n_total = r_total + TW'(dd);
                end
                n_c = r_c + CW'(1);
                if (sweep_last) begin
                    n_cfg_ok = 1'b1;
                    n_res    = ST_STARTED;
                end
            end
            S_MUL: begin
                n_lhs   = prod[PW-1:FRAC_W];
                n_si    = VW'(1);
                n_sj    = '0;
                n_slot  = '0;
                n_idone = 1'b0;
                n_pv    = 1'b0;
                n_cum   = '0;
            end
            S_SCAN: begin
                // Issue one slot read per cycle in row order.
                n_pv = 1'b0;
                if (!r_idone) begin
                    w_raddr = r_slot;
                    n_pv    = 1'b1;
                    n_pi    = r_si;
                    n_pj    = r_sj;
                    n_pslot = r_slot;
                    n_slot  = r_slot + AW'(1);
                    if (r_sj + VW'(1) == r_si) begin
                        n_sj = '0;
                        n_si = r_si + VW'(1);
                        if (NXW'(r_si) + NXW'(1) == nx) begin
                            n_idone = 1'b1;
                        end
                    end else begin
                        n_sj = r_sj + VW'(1);
                    end
                end
                // Accumulate the returned weight and test against u*total.
                if (r_pv && w_rd != '0) begin
                    n_cum = cum_new;
                end
                if (scan_hit) begin
                    n_total = r_total - TW'(w_rd);
                    w_we    = 1'b1;
                    w_waddr = r_pslot;
                    w_wdata = '0;
                    n_fi    = r_pi;
                    n_fj    = r_pj;
                end else if (scan_miss) begin
                    n_res = ST_INCOMPLETE;
                end
            end
            S_DEG_I: begin
                d_raddr = r_fi;
            end
            S_DEG_J: begin
                n_di    = d_rd + DEG_W'(1);
                d_we    = 1'b1;
                d_waddr = r_fi;
                d_wdata = d_rd + DEG_W'(1);
                d_raddr = r_fj;
            end
            S_DEG_W: begin
                n_dj    = d_rd + DEG_W'(1);
                d_we    = 1'b1;
                d_waddr = r_fj;
                d_wdata = d_rd + DEG_W'(1);
                n_sel   = 1'b0;
                n_k     = '0;
                n_rdone = 1'b0;
                n_qv    = 1'b0;
            end
            S_REFRESH: begin
                // Issue pair and degree reads for each vertex k of both rows.
                n_qv = 1'b0;
                if (!r_rdone) begin
                    if (r_k != ref_v) begin
                        w_raddr = slot_of(ref_hi, ref_lo);
                        d_raddr = r_k;
                        n_qv    = 1'b1;
                        n_qslot = slot_of(ref_hi, ref_lo);
                        n_qdv   = r_sel ? r_dj : r_di;
                    end
                    if (NXW'(r_k) + NXW'(1) == nx) begin
                        n_k = '0;
                        if (r_sel) begin
                            n_rdone = 1'b1;
                        end else begin
                            n_sel = 1'b1;
                        end
                    end else begin
                        n_k = r_k + VW'(1);
                    end
                end
                // Rewrite a positive weight and adjust the total.
                if (r_qv && w_rd != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_qslot;
                    w_wdata = fresh(r_td, r_qdv, d_rd);
                    n_total = r_total - TW'(w_rd) + TW'(fresh(r_td, r_qdv, d_rd));
                end
                if (ref_end) begin
                    n_edges  = r_edges + EW'(1);
                    n_res    = ST_EDGE;
                    n_res_hi = r_fi;
                    n_res_lo = r_fj;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res;
                    n_o_hi     = VTX_OUT_W'(r_res_hi);
                    n_o_lo     = VTX_OUT_W'(r_res_lo);
                    n_o_edges  = EDGE_OUT_W'(r_edges);
                end
            end
            default: begin
            end
        endcase

        // Register writes invalidate the current graph.
        if (cfg_we) begin
            if (paddr[2] == REG_TARGET_DEGREE) begin
                n_td = pwdata[CFG_W-1:0];
            end else begin
                n_nv = pwdata[CFG_W-1:0];
            end
            n_cfg_ok = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nv     <= RST_NUM_VERTICES;
            r_td     <= RST_TARGET_DEGREE;
            r_cfg_ok <= 1'b0;
            r_total  <= '0;
            r_edges  <= '0;
            r_ov     <= 1'b0;
            r_idone  <= 1'b0;
            r_pv     <= 1'b0;
            r_rdone  <= 1'b0;
            r_qv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nv     <= n_nv;
            r_td     <= n_td;
            r_cfg_ok <= n_cfg_ok;
            r_total  <= n_total;
            r_edges  <= n_edges;
            r_ov     <= n_ov;
            r_idone  <= n_idone;
            r_pv     <= n_pv;
            r_rdone  <= n_rdone;
            r_qv     <= n_qv;
        end
    end

    // Payload and loop registers.
    always_ff @(posedge i_clk) begin
        r_u        <= n_u;
        r_c        <= n_c;
        r_lhs      <= n_lhs;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_slot     <= n_slot;
        r_pi       <= n_pi;
        r_pj       <= n_pj;
        r_pslot    <= n_pslot;
        r_cum      <= n_cum;
        r_fi       <= n_fi;
        r_fj       <= n_fj;
        r_di       <= n_di;
        r_dj       <= n_dj;
        r_sel      <= n_sel;
        r_k        <= n_k;
        r_qslot    <= n_qslot;
        r_qdv      <= n_qdv;
        r_res      <= n_res;
        r_res_hi   <= n_res_hi;
        r_res_lo   <= n_res_lo;
        r_o_status <= n_o_status;
        r_o_hi     <= n_o_hi;
        r_o_lo     <= n_o_lo;
        r_o_edges  <= n_o_edges;
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_vertex_high = r_o_hi;
    assign o_vertex_low  = r_o_lo;
    assign o_edge_count  = r_o_edges;

endmodule

`default_nettype wire

// ----- hw/rtl/rgwep_checker.sv -----
// Port-level checker for the edge picker top level, attached by a bind statement.
// Depends on rgwep_pkg.
`default_nettype none

module rgwep_checker
    import rgwep_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [STATUS_W-1:0]   o_status,
    input wire logic [VTX_OUT_W-1:0]  o_vertex_high,
    input wire logic [VTX_OUT_W-1:0]  o_vertex_low
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // One item at a time: an input transfer closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in progress");

    // A stalled result holds its status.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)))
        else $error("stalled result changed");

    // Only an added edge carries vertex numbers.
    a_no_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_EDGE) |-> (o_vertex_high == '0 && o_vertex_low == '0))
        else $error("vertices reported without an edge");

    // Status is a defined code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_BAD_CONFIG))
        else $error("undefined status code");

endmodule

bind regular_graph_weighted_edge_picker_core rgwep_checker u_rgwep_checker (.*);

`default_nettype wire
